### rtl/hta_pkg.sv
package hta_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int IDX_W = 15;
	localparam int INST_W = 13;
	localparam int HOUT_W = 31;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_DUP = 3'd1;
	localparam logic [2:0] FN_LOOKUP = 3'd2;
	localparam logic [2:0] FN_CLOSE = 3'd3;
	localparam logic [2:0] FN_COUNT = 3'd4;
	localparam logic [2:0] FN_POP = 3'd5;
	localparam logic [2:0] FN_RELALL = 3'd6;

	localparam logic [1:0] OWNER_PROCESS = 2'd0;
	localparam logic [1:0] OWNER_THREAD = 2'd1;
	localparam logic [1:0] OWNER_KERNEL = 2'd2;
	localparam logic [1:0] HDL_LOCAL = 2'b01;

	typedef enum logic [2:0] {
		CMD_ADD,
		CMD_DUP,
		CMD_LOOKUP,
		CMD_CLOSE,
		CMD_COUNT,
		CMD_POP,
		CMD_RELALL,
		CMD_NONE
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] obj;
		logic [31:0] hdl;
		logic        idx_ok;
		logic        refused;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DUP_RD,
		ST_LOOKUP_RD,
		ST_FREE_SCAN,
		ST_CNT_RD,
		ST_CNT_CHK,
		ST_ERASE_RD,
		ST_ERASE_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_POP_RD
	} state_t;

endpackage

### rtl/hta_front.sv
module hta_front #(
	parameter int SLOTS = hta_pkg::SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [2:0]        func,
	input  logic [31:0]       object_id,
	input  logic [31:0]       handle,
	input  logic [1:0]        owner_kind,
	output logic              push,
	output hta_pkg::job_t     job
);

	logic          valid_s1;
	hta_pkg::job_t job_s1;
	hta_pkg::job_t job_c;

	always_comb begin
		job_c.obj = object_id;
		job_c.hdl = handle;
		job_c.idx_ok = {1'b0, handle[hta_pkg::IDX_W-1:0]} < 16'(SLOTS);
		job_c.refused = (owner_kind == hta_pkg::OWNER_PROCESS) &&
			(handle[31:30] != hta_pkg::HDL_LOCAL);
		case (func)
			hta_pkg::FN_ADD: job_c.cmd = hta_pkg::CMD_ADD;
			hta_pkg::FN_DUP: job_c.cmd = hta_pkg::CMD_DUP;
			hta_pkg::FN_LOOKUP: job_c.cmd = hta_pkg::CMD_LOOKUP;
			hta_pkg::FN_CLOSE: job_c.cmd = hta_pkg::CMD_CLOSE;
			hta_pkg::FN_COUNT: job_c.cmd = hta_pkg::CMD_COUNT;
			hta_pkg::FN_POP: job_c.cmd = hta_pkg::CMD_POP;
			hta_pkg::FN_RELALL: job_c.cmd = hta_pkg::CMD_RELALL;
			default: job_c.cmd = hta_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_c;
		end
	end

	assign push = valid_s1;
	assign job = job_s1;

endmodule

### rtl/hta_queue.sv
module hta_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hta_pkg::job_t push_job,
	input  logic          pop,
	output logic          valid,
	output hta_pkg::job_t head
);

	hta_pkg::job_t entry_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_job;
		end
	end

	assign valid = count_q != 2'd0;
	assign head = entry_q[rp_q];

endmodule

### rtl/hta_back.sv
module hta_back #(
	parameter int SLOTS = hta_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  hta_pkg::job_t              q_head,
	input  logic [1:0]                 owner_kind,
	output logic                       q_pop,
	output logic                       active,
	output logic                       done,
	output logic [hta_pkg::HOUT_W-1:0] handle_out,
	output logic [31:0]                object_out,
	output logic [hta_pkg::CNT_W-1:0]  match_count,
	output logic                       status
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW = $clog2(SLOTS + 1);

	hta_pkg::state_t state_q, state_d;
	hta_pkg::job_t   cur_q;
	logic [SLOTS-1:0] busy_q;
	logic [31:0] obj_mem [SLOTS];
	logic [hta_pkg::HOUT_W-1:0] stk_mem [SLOTS];
	logic [31:0] obj_rd_q;
	logic [hta_pkg::HOUT_W-1:0] stk_rd_q;
	logic [31:0] add_obj_q;
	logic [DW-1:0] scan_q;
	logic [DW-1:0] depth_q;
	logic [hta_pkg::INST_W-1:0] inst_q;
	logic [hta_pkg::CNT_W-1:0] cnt_q;
	logic done_q;
	logic [hta_pkg::HOUT_W-1:0] res_h_q;
	logic [31:0] res_obj_q;
	logic [hta_pkg::CNT_W-1:0] res_cnt_q;
	logic res_fail_q;

	logic [IW-1:0] scan_idx, cur_idx, obj_raddr, stk_raddr;
	logic slot_ok, free_hit, last_slot, stk_match, cnt_hit, room;
	logic [hta_pkg::CNT_W-1:0] cnt_nx;
	logic [hta_pkg::INST_W-1:0] inst_nx;
	logic [hta_pkg::HOUT_W-1:0] new_h;

	logic finish, fin_fail;
	logic [hta_pkg::HOUT_W-1:0] fin_h;
	logic [31:0] fin_obj;
	logic [hta_pkg::CNT_W-1:0] fin_cnt;
	logic scan_clr, scan_inc, cnt_clr, cnt_upd, depth_dec, alloc, clr_slot, clr_all;
	logic load_add_obj, stk_we;

	assign scan_idx = scan_q[IW-1:0];
	assign cur_idx = cur_q.hdl[IW-1:0];
	assign slot_ok = cur_q.idx_ok && busy_q[cur_idx];
	assign free_hit = !busy_q[scan_idx];
	assign last_slot = scan_q == DW'(SLOTS - 1);
	assign stk_match = {1'b0, stk_rd_q} == cur_q.hdl;
	assign cnt_hit = busy_q[scan_idx] && (obj_rd_q == cur_q.obj) && (cnt_q != hta_pkg::CNT_MAX);
	assign cnt_nx = cnt_q + hta_pkg::CNT_W'(cnt_hit);
	assign room = depth_q < DW'(SLOTS);
	assign inst_nx = inst_q + 1'b1;
	assign new_h = {owner_kind == hta_pkg::OWNER_THREAD, owner_kind == hta_pkg::OWNER_KERNEL,
		inst_nx, 1'b0, hta_pkg::IDX_W'(scan_idx)};

	assign obj_raddr = (state_q == hta_pkg::ST_DISPATCH) ? cur_idx : scan_idx;

	always_comb begin
		case (state_q)
			hta_pkg::ST_DISPATCH: stk_raddr = IW'(depth_q - 1'b1);
			hta_pkg::ST_SHIFT_RD: stk_raddr = IW'(scan_q + 1'b1);
			default: stk_raddr = scan_idx;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hta_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = hta_pkg::ST_DISPATCH;
				end
			end
			hta_pkg::ST_DISPATCH: begin
				state_d = hta_pkg::ST_IDLE;
				case (cur_q.cmd)
					hta_pkg::CMD_ADD: begin
						if (cur_q.obj != 32'd0) begin
							state_d = hta_pkg::ST_FREE_SCAN;
						end
					end
					hta_pkg::CMD_DUP: begin
						if (!cur_q.refused && slot_ok) begin
							state_d = hta_pkg::ST_DUP_RD;
						end
					end
					hta_pkg::CMD_LOOKUP: begin
						if (slot_ok) begin
							state_d = hta_pkg::ST_LOOKUP_RD;
						end
					end
					hta_pkg::CMD_CLOSE: begin
						if (slot_ok && depth_q != '0) begin
							state_d = hta_pkg::ST_ERASE_RD;
						end
					end
					hta_pkg::CMD_COUNT: state_d = hta_pkg::ST_CNT_RD;
					hta_pkg::CMD_POP: begin
						if (depth_q != '0) begin
							state_d = hta_pkg::ST_POP_RD;
						end
					end
					default: state_d = hta_pkg::ST_IDLE;
				endcase
			end
			hta_pkg::ST_DUP_RD: state_d = hta_pkg::ST_FREE_SCAN;
			hta_pkg::ST_LOOKUP_RD: state_d = hta_pkg::ST_IDLE;
			hta_pkg::ST_FREE_SCAN: begin
				if (free_hit || last_slot) begin
					state_d = hta_pkg::ST_IDLE;
				end
			end
			hta_pkg::ST_CNT_RD: state_d = hta_pkg::ST_CNT_CHK;
			hta_pkg::ST_CNT_CHK: begin
				state_d = last_slot ? hta_pkg::ST_IDLE : hta_pkg::ST_CNT_RD;
			end
			hta_pkg::ST_ERASE_RD: state_d = hta_pkg::ST_ERASE_CHK;
			hta_pkg::ST_ERASE_CHK: begin
				if (DW'(scan_q + 1'b1) >= depth_q) begin
					state_d = hta_pkg::ST_IDLE;
				end else begin
					state_d = stk_match ? hta_pkg::ST_SHIFT_RD : hta_pkg::ST_ERASE_RD;
				end
			end
			hta_pkg::ST_SHIFT_RD: state_d = hta_pkg::ST_SHIFT_WR;
			hta_pkg::ST_SHIFT_WR: begin
				if ((DW + 1)'(scan_q) + 2'd2 < (DW + 1)'(depth_q)) begin
					state_d = hta_pkg::ST_SHIFT_RD;
				end else begin
					state_d = hta_pkg::ST_IDLE;
				end
			end
			hta_pkg::ST_POP_RD: state_d = hta_pkg::ST_IDLE;
			default: state_d = hta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		finish = 1'b0;
		fin_fail = 1'b1;
		fin_h = '0;
		fin_obj = '0;
		fin_cnt = '0;
		scan_clr = 1'b0;
		scan_inc = 1'b0;
		cnt_clr = 1'b0;
		cnt_upd = 1'b0;
		depth_dec = 1'b0;
		alloc = 1'b0;
		clr_slot = 1'b0;
		clr_all = 1'b0;
		load_add_obj = 1'b0;
		stk_we = 1'b0;
		case (state_q)
			hta_pkg::ST_IDLE: q_pop = q_valid;
			hta_pkg::ST_DISPATCH: begin
				scan_clr = 1'b1;
				cnt_clr = 1'b1;
				case (cur_q.cmd)
					hta_pkg::CMD_ADD: begin
						load_add_obj = 1'b1;
						finish = cur_q.obj == 32'd0;
					end
					hta_pkg::CMD_DUP: finish = cur_q.refused || !slot_ok;
					hta_pkg::CMD_LOOKUP: finish = !slot_ok;
					hta_pkg::CMD_CLOSE: begin
						clr_slot = slot_ok;
						finish = !slot_ok || depth_q == '0;
						fin_fail = !slot_ok;
					end
					hta_pkg::CMD_COUNT: finish = 1'b0;
					hta_pkg::CMD_POP: begin
						depth_dec = depth_q != '0;
						finish = depth_q == '0;
					end
					hta_pkg::CMD_RELALL: begin
						clr_all = 1'b1;
						finish = 1'b1;
						fin_fail = 1'b0;
					end
					default: finish = 1'b1;
				endcase
			end
			hta_pkg::ST_DUP_RD: load_add_obj = 1'b1;
			hta_pkg::ST_LOOKUP_RD: begin
				finish = 1'b1;
				fin_fail = 1'b0;
				fin_obj = obj_rd_q;
			end
			hta_pkg::ST_FREE_SCAN: begin
				if (free_hit) begin
					alloc = 1'b1;
					stk_we = room;
					finish = 1'b1;
					fin_fail = 1'b0;
					fin_h = new_h;
				end else if (last_slot) begin
					finish = 1'b1;
				end else begin
					scan_inc = 1'b1;
				end
			end
			hta_pkg::ST_CNT_CHK: begin
				cnt_upd = 1'b1;
				scan_inc = 1'b1;
				finish = last_slot;
				fin_cnt = cnt_nx;
				fin_fail = cnt_nx == '0;
			end
			hta_pkg::ST_ERASE_CHK: begin
				if (DW'(scan_q + 1'b1) >= depth_q) begin
					depth_dec = stk_match;
					finish = 1'b1;
					fin_fail = 1'b0;
				end else if (!stk_match) begin
					scan_inc = 1'b1;
				end
			end
			hta_pkg::ST_SHIFT_WR: begin
				stk_we = 1'b1;
				scan_inc = 1'b1;
				if (!((DW + 1)'(scan_q) + 2'd2 < (DW + 1)'(depth_q))) begin
					depth_dec = 1'b1;
					finish = 1'b1;
					fin_fail = 1'b0;
				end
			end
			hta_pkg::ST_POP_RD: begin
				finish = 1'b1;
				fin_fail = 1'b0;
				fin_h = stk_rd_q;
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hta_pkg::ST_IDLE;
			busy_q <= '0;
			inst_q <= '0;
			depth_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= finish;
			if (clr_all) begin
				busy_q <= '0;
			end else if (clr_slot) begin
				busy_q[cur_idx] <= 1'b0;
			end else if (alloc) begin
				busy_q[scan_idx] <= 1'b1;
			end
			if (alloc) begin
				inst_q <= inst_nx;
			end
			if (alloc && room) begin
				depth_q <= depth_q + 1'b1;
			end else if (depth_dec) begin
				depth_q <= depth_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		obj_rd_q <= obj_mem[obj_raddr];
		stk_rd_q <= stk_mem[stk_raddr];
		if (alloc) begin
			obj_mem[scan_idx] <= add_obj_q;
		end
		if (stk_we) begin
			if (state_q == hta_pkg::ST_SHIFT_WR) begin
				stk_mem[scan_idx] <= stk_rd_q;
			end else begin
				stk_mem[depth_q[IW-1:0]] <= new_h;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (load_add_obj) begin
			add_obj_q <= (state_q == hta_pkg::ST_DUP_RD) ? obj_rd_q : cur_q.obj;
		end
		if (scan_clr) begin
			scan_q <= '0;
		end else if (scan_inc) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cnt_clr) begin
			cnt_q <= '0;
		end else if (cnt_upd) begin
			cnt_q <= cnt_nx;
		end
		if (finish) begin
			res_h_q <= fin_h;
			res_obj_q <= fin_obj;
			res_cnt_q <= fin_cnt;
			res_fail_q <= fin_fail;
		end
	end

	assign active = state_q != hta_pkg::ST_IDLE;
	assign done = done_q;
	assign handle_out = res_h_q;
	assign object_out = res_obj_q;
	assign match_count = res_cnt_q;
	assign status = res_fail_q;

endmodule

### rtl/handle_table_allocator.sv
// Release all and failed checks finish in the dispatch state; lookup and pop each read one entry;
// add and duplicate scan the slots for a free one; count walks every slot;
// close searches the handle stack and shifts the entries above the closed handle down.
// One item is in flight at a time: a new item is not accepted until busy falls.
// The result beat is shown for exactly one cycle on done; the receiver cannot stall it.
// Reset frees all slots, empties the handle stack and clears the instance counter.
module handle_table_allocator #(
	parameter int SLOTS = hta_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 func,
	input  logic [31:0]                object_id,
	input  logic [31:0]                handle,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_wdata,
	output logic                       done,
	output logic [hta_pkg::HOUT_W-1:0] handle_out,
	output logic [31:0]                object_out,
	output logic [hta_pkg::CNT_W-1:0]  match_count,
	output logic                       status
);

	logic [1:0]    owner_kind_q;
	logic          accept;
	logic          push;
	hta_pkg::job_t push_job;
	logic          q_valid;
	logic          q_pop;
	hta_pkg::job_t q_head;
	logic          active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_kind_q <= hta_pkg::OWNER_PROCESS;
		end else if (cfg_we) begin
			owner_kind_q <= cfg_wdata;
		end
	end

	assign accept = start && !busy;
	assign busy = push || q_valid || active;

	hta_front #(.SLOTS(SLOTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.func(func),
		.object_id(object_id),
		.handle(handle),
		.owner_kind(owner_kind_q),
		.push(push),
		.job(push_job)
	);

	hta_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(q_pop),
		.valid(q_valid),
		.head(q_head)
	);

	hta_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.owner_kind(owner_kind_q),
		.q_pop(q_pop),
		.active(active),
		.done(done),
		.handle_out(handle_out),
		.object_out(object_out),
		.match_count(match_count),
		.status(status)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without an item in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && match_count != '0 |-> status == 1'b0)
		else $error("nonzero match count reported as failure");

	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && object_out != 32'd0 |-> status == 1'b0)
		else $error("found object reported as failure");

endmodule

### sim/tb.sv
module tb;

	typedef struct {
		logic [30:0] hout;
		logic [31:0] oout;
		logic [6:0]  cnt;
		logic        fail;
	} reply_t;

	class table_scoreboard;
		bit          busy_slot [64];
		logic [31:0] obj_slot [64];
		logic [12:0] inst;
		logic [31:0] stk [64];
		int          depth;
		logic [1:0]  owner;
		reply_t      pending [$];
		int          errors;

		function new();
			for (int i = 0; i < 64; i++) begin
				busy_slot[i] = 0;
				obj_slot[i] = 0;
			end
			inst = 0;
			depth = 0;
			owner = hta_pkg::OWNER_PROCESS;
			errors = 0;
		endfunction

		function bit add_obj(logic [31:0] obj, output logic [31:0] h);
			int i;
			h = 0;
			if (obj == 0)
				return 0;
			for (i = 0; i < 64; i++)
				if (!busy_slot[i])
					break;
			if (i >= 64)
				return 0;
			inst = inst + 13'd1;
			h = {3'b000, inst, 1'b0, 15'(i)};
			if (owner == hta_pkg::OWNER_THREAD)
				h[30] = 1'b1;
			if (owner == hta_pkg::OWNER_KERNEL)
				h[29] = 1'b1;
			if (depth < 64) begin
				stk[depth] = h;
				depth++;
			end
			busy_slot[i] = 1;
			obj_slot[i] = obj;
			return 1;
		endfunction

		function logic [31:0] find_obj(logic [31:0] h);
			if (h[14:0] >= 64 || !busy_slot[h[5:0]])
				return 0;
			return obj_slot[h[5:0]];
		endfunction

		function void note(logic [2:0] f, logic [31:0] obj, logic [31:0] h);
			reply_t r;
			logic [31:0] hn;
			logic [31:0] found;
			int j;
			r.hout = 0;
			r.oout = 0;
			r.cnt = 0;
			r.fail = 1;
			hn = 0;
			case (f)
				hta_pkg::FN_ADD: begin
					if (add_obj(obj, hn))
						r.fail = 0;
				end
				hta_pkg::FN_DUP: begin
					if (!(owner == hta_pkg::OWNER_PROCESS && h[31:30] != hta_pkg::HDL_LOCAL)) begin
						found = find_obj(h);
						if (found != 0 && add_obj(found, hn))
							r.fail = 0;
					end
				end
				hta_pkg::FN_LOOKUP: begin
					r.oout = find_obj(h);
					r.fail = (r.oout == 0);
				end
				hta_pkg::FN_CLOSE: begin
					if (h[14:0] < 64 && busy_slot[h[5:0]]) begin
						busy_slot[h[5:0]] = 0;
						obj_slot[h[5:0]] = 0;
						for (j = 0; j < depth; j++)
							if (stk[j] == h)
								break;
						if (j < depth) begin
							for (; j + 1 < depth; j++)
								stk[j] = stk[j + 1];
							depth--;
						end
						r.fail = 0;
					end
				end
				hta_pkg::FN_COUNT: begin
					for (j = 0; j < 64; j++)
						if (busy_slot[j] && obj_slot[j] == obj && r.cnt < hta_pkg::CNT_MAX)
							r.cnt++;
					r.fail = (r.cnt == 0);
				end
				hta_pkg::FN_POP: begin
					if (depth > 0) begin
						depth--;
						hn = stk[depth];
						r.fail = 0;
					end
				end
				hta_pkg::FN_RELALL: begin
					for (j = 0; j < 64; j++) begin
						busy_slot[j] = 0;
						obj_slot[j] = 0;
					end
					r.fail = 0;
				end
				default: ;
			endcase
			r.hout = hn[30:0];
			pending.insert(pending.size(), r);
		endfunction

		function void check(reply_t a);
			reply_t e;
			if (pending.size() == 0) begin
				$display("%0t: result beat with nothing expected: handle_out %h", $time, a.hout);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.hout !== e.hout) begin
				$display("%0t: handle_out expected %h actual %h", $time, e.hout, a.hout);
				errors++;
			end
			if (a.oout !== e.oout) begin
				$display("%0t: object_out expected %h actual %h", $time, e.oout, a.oout);
				errors++;
			end
			if (a.cnt !== e.cnt) begin
				$display("%0t: match_count expected %0d actual %0d", $time, e.cnt, a.cnt);
				errors++;
			end
			if (a.fail !== e.fail) begin
				$display("%0t: status expected %b actual %b", $time, e.fail, a.fail);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [31:0] object_id;
	logic [31:0] handle;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        done;
	logic [30:0] handle_out;
	logic [31:0] object_out;
	logic [6:0]  match_count;
	logic        status;

	table_scoreboard sb = new();
	int cycles = 0;

	handle_table_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.object_id(object_id), .handle(handle), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .handle_out(handle_out), .object_out(object_out),
		.match_count(match_count), .status(status)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		reply_t a;
		cycles++;
		if (arst_n && done) begin
			a.hout = handle_out;
			a.oout = object_out;
			a.cnt = match_count;
			a.fail = status;
			sb.check(a);
		end
		if (cycles > 1000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic issue(logic [2:0] f, logic [31:0] obj, logic [31:0] h);
		int g;
		func <= f;
		object_id <= obj;
		handle <= h;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note(f, obj, h);
		@(negedge clk);
		g = $urandom_range(0, 8);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic set_owner(logic [1:0] v);
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		sb.owner = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_object();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return $urandom();
			2: return 32'h0;
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic logic [31:0] pick_handle();
		logic [31:0] h;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if (sb.depth > 0)
					h = sb.stk[$urandom_range(0, sb.depth - 1)];
				else
					h = {26'($urandom()), 6'($urandom_range(0, 63))};
				if ($urandom_range(0, 2) == 0)
					h[31:30] = hta_pkg::HDL_LOCAL;
			end
			5, 6, 7: h = {$urandom_range(0, 3) == 0 ? hta_pkg::HDL_LOCAL : 2'($urandom()),
				15'($urandom()), 9'd0, 6'($urandom_range(0, 63))};
			8: h = {17'($urandom()), 15'($urandom_range(64, 32767))};
			default: h = $urandom();
		endcase
		return h;
	endfunction

	initial begin
		int r;
		int fill;
		logic [1:0] owners [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd3};
		arst_n = 1'b0;
		start = 1'b0;
		func = hta_pkg::FN_ADD;
		object_id = 0;
		handle = 0;
		cfg_we = 1'b0;
		cfg_wdata = hta_pkg::OWNER_PROCESS;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_owner(hta_pkg::OWNER_THREAD);
		issue(hta_pkg::FN_ADD, 32'h1, 0);
		issue(hta_pkg::FN_ADD, 32'hFFFF_FFFF, 0);
		issue(hta_pkg::FN_ADD, 32'h0, 0);
		issue(hta_pkg::FN_DUP, sb.stk[0], sb.stk[0]);
		issue(hta_pkg::FN_LOOKUP, 0, sb.stk[1]);
		issue(hta_pkg::FN_LOOKUP, 0, 32'h0000_7FFF);
		issue(hta_pkg::FN_LOOKUP, 0, 32'h0000_0030);
		issue(hta_pkg::FN_COUNT, 32'h1, 0);
		issue(hta_pkg::FN_COUNT, 32'h5, 0);
		set_owner(hta_pkg::OWNER_PROCESS);
		issue(hta_pkg::FN_DUP, 0, 32'h8000_0001);
		issue(hta_pkg::FN_DUP, 0, 32'h4000_0001);
		issue(hta_pkg::FN_POP, 0, 0);
		issue(hta_pkg::FN_CLOSE, 0, sb.stk[0] ^ 32'h0001_0000);
		issue(hta_pkg::FN_CLOSE, 0, 32'h0000_0030);
		issue(hta_pkg::FN_POP, 0, 0);
		issue(hta_pkg::FN_POP, 0, 0);
		issue(hta_pkg::FN_POP, 0, 0);
		issue(3'(hta_pkg::CMD_NONE), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(hta_pkg::FN_RELALL, 0, 0);
		set_owner(hta_pkg::OWNER_KERNEL);
		issue(hta_pkg::FN_ADD, 32'h7, 0);
		issue(hta_pkg::FN_CLOSE, 0, sb.stk[0]);

		for (int p = 0; p < 8; p++) begin
			set_owner(owners[p]);
			fill = (p % 2 == 0) ? 70 : 35;
			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < fill)
					issue($urandom_range(0, 2) == 0 ? hta_pkg::FN_DUP : hta_pkg::FN_ADD,
						pick_object(), pick_handle());
				else if (r < fill + 8)
					issue(hta_pkg::FN_LOOKUP, pick_object(), pick_handle());
				else if (r < fill + 16)
					issue(hta_pkg::FN_CLOSE, pick_object(), pick_handle());
				else if (r < fill + 22)
					issue(hta_pkg::FN_COUNT, pick_object(), pick_handle());
				else if (r < fill + 27)
					issue(hta_pkg::FN_POP, pick_object(), pick_handle());
				else if (r < fill + 29)
					issue(hta_pkg::FN_RELALL, pick_object(), pick_handle());
				else
					issue(3'($urandom()), pick_object(), pick_handle());
			end
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
